>>> rtl/core/lmt_pkg.sv
// ----------------------------------------------------------------------------
// lmt_pkg
// Shared types and constants of the 3x3 local mean threshold block.
// ----------------------------------------------------------------------------
package lmt_pkg;

  localparam int CFG_BITS     = 11;
  localparam int CFG_IDX_BITS = 2;
  localparam int ROW_BITS     = 12;

  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 11'd480;
  localparam logic [CFG_BITS-1:0] SIZE_MIN     = 11'd3;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // position class of the pixel judged for one request
  typedef struct packed {
    logic produce;
    logic top;
    logic bot;
    logic lef;
    logic rig;
  } pos_flags_t;

endpackage

>>> rtl/core/lmt_ctrl.sv
// ----------------------------------------------------------------------------
// lmt_ctrl
// Frame size registers, column/row/pending counters and position decode.
// ----------------------------------------------------------------------------
module lmt_ctrl #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [lmt_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [lmt_pkg::CFG_BITS-1:0]      cfg_data,
  input  logic                              accept,
  input  logic                              op,
  input  logic [PIXEL_BITS-1:0]             pixel,
  output logic                              push,
  output logic [$clog2(MAX_WIDTH)-1:0]      addr,
  output logic [PIXEL_BITS-1:0]             bottom,
  output lmt_pkg::pos_flags_t               flags
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;
  localparam int PW = $clog2(MAX_WIDTH + 2);
  localparam int RW = lmt_pkg::ROW_BITS;

  logic [lmt_pkg::CFG_BITS-1:0] frame_width;
  logic [lmt_pkg::CFG_BITS-1:0] frame_height;
  logic [CW-1:0]                col;
  logic [RW-1:0]                row;
  logic [PW-1:0]                pending;

  logic [31:0]                  w32;
  logic [WW-1:0]                w;
  logic [lmt_pkg::CFG_BITS-1:0] h;
  logic [RW-1:0]                h_ext;
  logic                         is_pixel;
  logic                         restart;
  logic [CW-1:0]                c_eff;
  logic [RW-1:0]                r_eff;
  logic [WW-1:0]                c_inc;
  logic                         wrap;
  logic [CW-1:0]                col_next;
  logic [RW-1:0]                row_next;
  logic [PW-1:0]                pending_next;
  logic [31:0]                  w_plus;
  logic [PW-1:0]                pend_dec;

  always_comb begin
    if (frame_width < lmt_pkg::SIZE_MIN) begin
      w32 = 32'(lmt_pkg::SIZE_MIN);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      w32 = 32'(MAX_WIDTH);
    end else begin
      w32 = 32'(frame_width);
    end
    w = w32[WW-1:0];
    h = (frame_height < lmt_pkg::SIZE_MIN) ? lmt_pkg::SIZE_MIN : frame_height;
    h_ext = {1'b0, h};
    w_plus = w32 + 32'd1;

    is_pixel = (op == lmt_pkg::OP_PIXEL);
    restart  = (pending != '0) || (row >= h_ext);
    if (is_pixel && restart) begin
      c_eff = '0;
      r_eff = '0;
    end else begin
      c_eff = col;
      r_eff = row;
    end
    push   = accept && (is_pixel || (pending != '0));
    addr   = c_eff;
    bottom = is_pixel ? pixel : '0;

    c_inc    = {1'b0, c_eff} + WW'(1);
    wrap     = (c_inc >= w);
    col_next = wrap ? '0 : c_inc[CW-1:0];
    row_next = r_eff + RW'(wrap);
    pend_dec = pending - PW'(1);
    if (is_pixel) begin
      pending_next = (row_next >= h_ext) ? w_plus[PW-1:0] : '0;
    end else begin
      pending_next = pend_dec;
    end

    // judged pixel sits one line and one column behind
    if (c_eff != '0) begin
      flags.top = (r_eff == RW'(1));
      flags.bot = (r_eff == h_ext);
      flags.lef = (c_eff == CW'(1));
      flags.rig = 1'b0;
    end else begin
      flags.top = (r_eff == RW'(2));
      flags.bot = (r_eff == h_ext + RW'(1));
      flags.lef = 1'b0;
      flags.rig = 1'b1;
    end
    flags.produce = !is_pixel || (r_eff >= RW'(2)) || ((r_eff == RW'(1)) && (c_eff != '0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= lmt_pkg::WIDTH_RESET;
      frame_height <= lmt_pkg::HEIGHT_RESET;
      col          <= '0;
      row          <= '0;
      pending      <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lmt_pkg::REG_FRAME_WIDTH: begin
          frame_width <= cfg_data;
          col         <= '0;
          row         <= '0;
          pending     <= '0;
        end
        lmt_pkg::REG_FRAME_HEIGHT: begin
          frame_height <= cfg_data;
          col          <= '0;
          row          <= '0;
          pending      <= '0;
        end
        default: begin
        end
      endcase
    end else if (push) begin
      if (!is_pixel && (pend_dec == '0)) begin
        col     <= '0;
        row     <= '0;
        pending <= '0;
      end else begin
        col     <= col_next;
        row     <= row_next;
        pending <= pending_next;
      end
    end
  end

endmodule

>>> rtl/core/lmt_linebuf.sv
// ----------------------------------------------------------------------------
// lmt_linebuf
// Two-line store memory with read-modify-write per column, plus the 3x3 window.
// ----------------------------------------------------------------------------
module lmt_linebuf #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 adv,
  input  logic                                 push,
  input  logic [$clog2(MAX_WIDTH)-1:0]         addr,
  input  logic [PIXEL_BITS-1:0]                bottom,
  input  lmt_pkg::pos_flags_t                  flags,
  output logic [2:0][2:0][PIXEL_BITS-1:0]      win,
  output logic                                 s2_valid,
  output lmt_pkg::pos_flags_t                  s2_flags
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int PB = PIXEL_BITS;

  // entry = {older line, newer line}
  logic [2*PB-1:0]     mem [MAX_WIDTH];
  logic [2*PB-1:0]     mem_q;
  logic                fwd;
  logic [2*PB-1:0]     fwd_data;

  logic                s1_valid;
  logic [CW-1:0]       s1_addr;
  logic [PB-1:0]       s1_bottom;
  lmt_pkg::pos_flags_t s1_flags;

  logic [2*PB-1:0]     rd;
  logic [PB-1:0]       rd_a;
  logic [PB-1:0]       rd_b;
  logic [2*PB-1:0]     wr_data;
  logic                wr_en;

  always_comb begin
    rd      = fwd ? fwd_data : mem_q;
    rd_a    = rd[PB-1:0];
    rd_b    = rd[2*PB-1:PB];
    wr_data = {rd_a, s1_bottom};
    wr_en   = s1_valid && adv;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_q    <= mem[addr];
      fwd      <= wr_en && (s1_addr == addr);
      fwd_data <= wr_data;
    end
    if (wr_en) begin
      mem[s1_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      win      <= '0;
    end else if (adv) begin
      s1_valid <= push;
      s2_valid <= s1_valid;
      if (s1_valid) begin
        for (int r = 0; r < 3; r++) begin
          win[r][0] <= win[r][1];
          win[r][1] <= win[r][2];
        end
        win[0][2] <= rd_b;
        win[1][2] <= rd_a;
        win[2][2] <= s1_bottom;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_addr   <= addr;
      s1_bottom <= bottom;
      s1_flags  <= flags;
      s2_flags  <= s1_flags;
    end
  end

endmodule

>>> rtl/core/lmt_judge.sv
// ----------------------------------------------------------------------------
// lmt_judge
// Neighbor sum, mean compare and the output register.
// ----------------------------------------------------------------------------
module lmt_judge #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            adv,
  input  logic [2:0][2:0][PIXEL_BITS-1:0] win,
  input  logic                            s2_valid,
  input  lmt_pkg::pos_flags_t             s2_flags,
  output logic                            out_valid,
  output logic                            mark,
  output logic                            frame_end
);

  localparam int SW = PIXEL_BITS + 3;

  logic [SW-1:0] ctr;
  logic [SW-1:0] s5;
  logic [SW-1:0] s8;
  logic [SW-1:0] lim5;
  logic          mark_next;

  function automatic logic [SW-1:0] ext(input logic [PIXEL_BITS-1:0] v);
    ext = {3'b000, v};
  endfunction

  always_comb begin
    ctr = ext(win[1][1]);
    s8  = ext(win[0][0]) + ext(win[0][1]) + ext(win[0][2]) + ext(win[1][0])
        + ext(win[1][2]) + ext(win[2][0]) + ext(win[2][1]) + ext(win[2][2]);
    if (s2_flags.top) begin
      s5 = ext(win[1][0]) + ext(win[1][2]) + ext(win[2][0]) + ext(win[2][1]) + ext(win[2][2]);
    end else if (s2_flags.bot) begin
      s5 = ext(win[1][0]) + ext(win[1][2]) + ext(win[0][0]) + ext(win[0][1]) + ext(win[0][2]);
    end else if (s2_flags.lef) begin
      s5 = ext(win[0][1]) + ext(win[2][1]) + ext(win[0][2]) + ext(win[2][2]) + ext(win[1][2]);
    end else begin
      s5 = ext(win[0][1]) + ext(win[2][1]) + ext(win[0][0]) + ext(win[2][0]) + ext(win[1][0]);
    end
    // floor(s5 / 5) > ctr  <=>  s5 > 5*ctr + 4
    lim5 = (ctr << 2) + ctr + SW'(4);
    if ((s2_flags.top || s2_flags.bot) && (s2_flags.lef || s2_flags.rig)) begin
      mark_next = 1'b0;
    end else if (s2_flags.top || s2_flags.bot || s2_flags.lef || s2_flags.rig) begin
      mark_next = (s5 > lim5);
    end else begin
      mark_next = ((s8 >> 3) > ctr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s2_valid && s2_flags.produce;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mark      <= mark_next;
      frame_end <= s2_flags.bot && s2_flags.rig;
    end
  end

endmodule

>>> rtl/core/local_mean_threshold_3x3.sv
// ----------------------------------------------------------------------------
// local_mean_threshold_3x3
// 3x3 adaptive mean threshold over a raster pixel stream, one mark per pixel.
//
//   channel | direction | handshake           | payload
//   input   | in        | in_valid / in_stall | op, pixel
//   output  | out       | out_valid/out_stall | mark, frame_end
//   config  | in        | cfg_write           | cfg_index, cfg_data
//
// One request per cycle sustained while the output is not stalled; a request
// passes line store read, window update and compare to the output register.
// Line store needs no clearing; reset sets sizes, counters, valids, window.
// The pipeline holds in place while the output register is full and stalled.
// ----------------------------------------------------------------------------
module local_mean_threshold_3x3 #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [lmt_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [lmt_pkg::CFG_BITS-1:0]     cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             op,
  input  logic [PIXEL_BITS-1:0]            pixel,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             mark,
  output logic                             frame_end
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic                                adv;
  logic                                accept;
  logic                                push;
  logic [CW-1:0]                       addr;
  logic [PIXEL_BITS-1:0]               bottom;
  lmt_pkg::pos_flags_t                 flags;
  logic [2:0][2:0][PIXEL_BITS-1:0]     win;
  logic                                s2_valid;
  lmt_pkg::pos_flags_t                 s2_flags;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  lmt_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .op        (op),
    .pixel     (pixel),
    .push      (push),
    .addr      (addr),
    .bottom    (bottom),
    .flags     (flags)
  );

  lmt_linebuf #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_linebuf (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .push     (push),
    .addr     (addr),
    .bottom   (bottom),
    .flags    (flags),
    .win      (win),
    .s2_valid (s2_valid),
    .s2_flags (s2_flags)
  );

  lmt_judge #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_judge (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .win       (win),
    .s2_valid  (s2_valid),
    .s2_flags  (s2_flags),
    .out_valid (out_valid),
    .mark      (mark),
    .frame_end (frame_end)
  );

endmodule

>>> dv/local_mean_threshold_3x3_tb.sv
// ----------------------------------------------------------------------------
// local_mean_threshold_3x3_tb
// Self-checking bench for the 3x3 local mean threshold block. A behavioral
// model tracks the line stores, window and frame position. It predicts the
// mark and frame_end bit owed, if any, per accepted request. Directed frames
// cover clamped sizes, ignored register indexes, early pixels, idle flushes
// and a restart during drain. Long lines and a long output hold-off follow.
// A random run of frames then goes through many sizes, with bursty input
// and a stalling receiver.
// ----------------------------------------------------------------------------
module local_mean_threshold_3x3_tb;

  localparam int MAX_LINE     = 1024;
  localparam int PIX_BITS     = 8;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 150;

  // indexes past the two registers; writes to them do nothing
  localparam logic [lmt_pkg::CFG_IDX_BITS-1:0] REG_SPARE_A = 2'd2;
  localparam logic [lmt_pkg::CFG_IDX_BITS-1:0] REG_SPARE_B = 2'd3;

  localparam int STALL_NONE    = 0;
  localparam int STALL_LIGHT   = 1;
  localparam int STALL_HEAVY   = 2;
  localparam int STALL_PATTERN = 3;

  localparam int STYLE_ANY        = 0;
  localparam int STYLE_EXTREME    = 1;
  localparam int STYLE_FLAT       = 2;
  localparam int STYLE_DARK_LIGHT = 3;

  typedef struct packed {
    logic mark;
    logic frame_end;
  } mark_t;

  logic                             clk       = 1'b0;
  logic                             rst       = 1'b1;
  logic                             cfg_write = 1'b0;
  logic [lmt_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [lmt_pkg::CFG_BITS-1:0]     cfg_data  = '0;
  logic                             in_valid  = 1'b0;
  logic                             in_stall;
  logic                             op        = lmt_pkg::OP_PIXEL;
  logic [PIX_BITS-1:0]              pixel     = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic                             mark;
  logic                             frame_end;

  local_mean_threshold_3x3 u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .pixel     (pixel),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .mark      (mark),
    .frame_end (frame_end)
  );

  always #5 clk = ~clk;

  // model state
  logic [lmt_pkg::CFG_BITS-1:0] width_reg;
  logic [lmt_pkg::CFG_BITS-1:0] height_reg;
  bit [7:0]                     line_above     [MAX_LINE];
  bit [7:0]                     line_two_above [MAX_LINE];
  bit [7:0]                     win [3][3];
  int unsigned                  col_pos;
  int unsigned                  row_pos;
  int unsigned                  owed;

  mark_t marks_due[$];
  int    fail_count    = 0;
  int    items_sent    = 0;
  int    cycle_count   = 0;
  int    burst_left    = 0;
  bit    gaps_on       = 1'b0;
  int    stall_mode    = STALL_NONE;
  int    hold_requests = 0;
  int    hold_seen     = 0;
  int    hold_left     = 0;
  int    pattern_step  = 0;

  function automatic int unsigned line_len();
    int unsigned w;
    w = width_reg;
    if (w < 3) w = 3;
    if (w > MAX_LINE) w = MAX_LINE;
    return w;
  endfunction

  function automatic int unsigned frame_rows();
    return (height_reg < 3) ? 3 : height_reg;
  endfunction

  function automatic void restart_frame();
    col_pos = 0;
    row_pos = 0;
    owed    = 0;
  endfunction

  function automatic void apply_register(logic [lmt_pkg::CFG_IDX_BITS-1:0] idx,
                                         logic [lmt_pkg::CFG_BITS-1:0] data);
    if (idx == lmt_pkg::REG_FRAME_WIDTH) begin
      width_reg = data;
      restart_frame();
    end else if (idx == lmt_pkg::REG_FRAME_HEIGHT) begin
      height_reg = data;
      restart_frame();
    end
  endfunction

  // new column enters the window on the right; line stores rotate
  function automatic void shift_in(bit [7:0] px, int unsigned w);
    int unsigned c;
    c = col_pos;
    if (c >= w) c = 0;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = line_two_above[c];
    win[1][2] = line_above[c];
    win[2][2] = px;
    line_two_above[c] = line_above[c];
    line_above[c]     = px;
    c++;
    if (c >= w) begin
      c = 0;
      row_pos++;
    end
    col_pos = c;
  endfunction

  function automatic mark_t judge_center(int unsigned r, int unsigned c,
                                         int unsigned w, int unsigned h);
    int unsigned pr, pc, sum;
    bit at_top, at_bot, at_lef, at_rig;
    mark_t res;
    if (c >= 1) begin
      pr = r - 1;
      pc = c - 1;
    end else begin
      pr = r - 2;
      pc = w - 1;
    end
    at_top = (pr == 0);
    at_bot = (pr == h - 1);
    at_lef = (pc == 0);
    at_rig = (pc == w - 1);
    res = '0;
    if ((at_top || at_bot) && (at_lef || at_rig)) begin
      res.mark = 1'b0;
    end else if (at_top) begin
      sum = win[1][0] + win[1][2] + win[2][0] + win[2][1] + win[2][2];
      res.mark = (sum / 5) > win[1][1];
    end else if (at_bot) begin
      sum = win[1][0] + win[1][2] + win[0][0] + win[0][1] + win[0][2];
      res.mark = (sum / 5) > win[1][1];
    end else if (at_lef) begin
      sum = win[0][1] + win[2][1] + win[0][2] + win[2][2] + win[1][2];
      res.mark = (sum / 5) > win[1][1];
    end else if (at_rig) begin
      sum = win[0][1] + win[2][1] + win[0][0] + win[2][0] + win[1][0];
      res.mark = (sum / 5) > win[1][1];
    end else begin
      sum = win[0][0] + win[0][1] + win[0][2] + win[1][0]
          + win[1][2] + win[2][0] + win[2][1] + win[2][2];
      res.mark = (sum >> 3) > win[1][1];
    end
    res.frame_end = at_bot && at_rig;
    return res;
  endfunction

  function automatic bit predict_request(input logic req_op, input logic [7:0] px,
                                         output mark_t res);
    int unsigned w, h, r, c;
    w = line_len();
    h = frame_rows();
    res = '0;
    if (req_op == lmt_pkg::OP_PIXEL) begin
      if (owed > 0 || row_pos >= h || col_pos >= w) restart_frame();
      r = row_pos;
      c = col_pos;
      shift_in(px, w);
      if (row_pos >= h) owed = w + 1;
      if (r >= 2 || (r == 1 && c >= 1)) begin
        res = judge_center(r, c, w, h);
        return 1'b1;
      end
      return 1'b0;
    end
    if (owed == 0) return 1'b0;
    r = row_pos;
    c = col_pos;
    shift_in(8'd0, w);
    res = judge_center(r, c, w, h);
    owed--;
    if (owed == 0) restart_frame();
    return 1'b1;
  endfunction

  function automatic logic [7:0] pick_pixel(int style, int base);
    int v;
    case (style)
      STYLE_EXTREME:    v = $urandom_range(0, 1) ? 255 : 0;
      STYLE_FLAT:       v = base + int'($urandom_range(0, 4)) - 2;
      STYLE_DARK_LIGHT: v = $urandom_range(0, 1) ? $urandom_range(0, 3)
                                                 : $urandom_range(252, 255);
      default:          v = $urandom_range(0, 255);
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // one request; returns at the edge that accepted it with valid still high
  task automatic send_request(input logic req_op, input logic [7:0] req_px);
    mark_t res;
    int    gap;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    op       <= req_op;
    pixel    <= req_px;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (predict_request(req_op, req_px, res)) begin
      marks_due.push_back(res);
      items_sent++;
    end else if (req_op == lmt_pkg::OP_PIXEL) begin
      items_sent++;
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (marks_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [lmt_pkg::CFG_IDX_BITS-1:0] idx,
                                input logic [lmt_pkg::CFG_BITS-1:0] data);
    settle();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    apply_register(idx, data);
  endtask

  task automatic set_frame(input logic [lmt_pkg::CFG_BITS-1:0] w,
                           input logic [lmt_pkg::CFG_BITS-1:0] h);
    if ($urandom_range(0, 1)) begin
      write_register(lmt_pkg::REG_FRAME_WIDTH, w);
      write_register(lmt_pkg::REG_FRAME_HEIGHT, h);
    end else begin
      write_register(lmt_pkg::REG_FRAME_HEIGHT, h);
      write_register(lmt_pkg::REG_FRAME_WIDTH, w);
    end
  endtask

  task automatic send_frame(int unsigned w, int unsigned h, int style, int base,
                            int unsigned nflush);
    repeat (w * h) send_request(lmt_pkg::OP_PIXEL, pick_pixel(style, base));
    repeat (nflush) send_request(lmt_pkg::OP_FLUSH, 8'($urandom_range(0, 255)));
  endtask

  task automatic test_directed_cases();
    logic [7:0] cross_px [9];
    cross_px = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0};
    stall_mode = STALL_NONE;
    gaps_on    = 1'b0;
    // default 640x480: early pixels give nothing
    repeat (4) send_request(lmt_pkg::OP_PIXEL, 8'd255);
    // both sizes below range, clamped to 3x3
    write_register(lmt_pkg::REG_FRAME_WIDTH, 11'd0);
    write_register(lmt_pkg::REG_FRAME_HEIGHT, 11'd2);
    for (int i = 0; i < 6; i++) send_request(lmt_pkg::OP_PIXEL, cross_px[i]);
    // spare index mid-frame: frame must carry on
    write_register(REG_SPARE_A, '1);
    for (int i = 6; i < 9; i++) send_request(lmt_pkg::OP_PIXEL, cross_px[i]);
    // four flushes drain the remaining pixels, the fifth is idle
    repeat (5) send_request(lmt_pkg::OP_FLUSH, 8'($urandom_range(0, 255)));
    for (int i = 0; i < 9; i++) send_request(lmt_pkg::OP_PIXEL, ~cross_px[i]);
    repeat (2) send_request(lmt_pkg::OP_FLUSH, 8'($urandom_range(0, 255)));
    // pixel during drain drops the rest and restarts
    for (int i = 0; i < 5; i++) send_request(lmt_pkg::OP_PIXEL, cross_px[i]);
    write_register(REG_SPARE_B, '0);
    for (int i = 5; i < 9; i++) send_request(lmt_pkg::OP_PIXEL, cross_px[i]);
    repeat (4) send_request(lmt_pkg::OP_FLUSH, 8'($urandom_range(0, 255)));
  endtask

  task automatic test_output_backpressure();
    write_register(lmt_pkg::REG_FRAME_WIDTH, 11'd8);
    write_register(lmt_pkg::REG_FRAME_HEIGHT, 11'd6);
    stall_mode = STALL_NONE;
    gaps_on    = 1'b0;
    hold_requests <= hold_requests + 1;
    send_frame(8, 6, STYLE_FLAT, 100, 9);
    stall_mode = STALL_PATTERN;
    gaps_on    = 1'b1;
    burst_left = 0;
    send_frame(8, 6, STYLE_EXTREME, 0, 9);
  endtask

  task automatic test_wide_lines();
    stall_mode = STALL_LIGHT;
    gaps_on    = 1'b1;
    burst_left = 0;
    // above the line store size: clamped to the longest line
    set_frame(11'd2047, 11'd2047);
    repeat (MAX_LINE + 6) send_request(lmt_pkg::OP_PIXEL, pick_pixel(STYLE_DARK_LIGHT, 0));
  endtask

  task automatic test_random_frames();
    logic [lmt_pkg::CFG_BITS-1:0] wreg, hreg;
    int unsigned                  w, h, nflush;
    int                           start, style, base, kind;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       wreg = 11'($urandom_range(0, 2));
        1:       wreg = 11'($urandom_range(13, 40));
        default: wreg = 11'($urandom_range(3, 12));
      endcase
      case ($urandom_range(0, 9))
        0:       hreg = 11'($urandom_range(0, 2));
        1:       hreg = 11'($urandom_range(9, 16));
        default: hreg = 11'($urandom_range(3, 8));
      endcase
      set_frame(wreg, hreg);
      w = line_len();
      h = frame_rows();
      stall_mode = $urandom_range(STALL_NONE, STALL_PATTERN);
      gaps_on    = ($urandom_range(0, 3) != 0);
      burst_left = 0;
      repeat ($urandom_range(1, 3)) begin
        style = $urandom_range(STYLE_ANY, STYLE_DARK_LIGHT);
        base  = $urandom_range(0, 255);
        kind  = $urandom_range(0, 9);
        if (kind == 9) begin
          repeat ($urandom_range(1, 2 * w))
            send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end else begin
          if (kind < 7)
            nflush = w + 1 + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
          else
            nflush = $urandom_range(0, w);
          send_frame(w, h, style, base, nflush);
        end
      end
    end
  endtask

  initial begin
    width_reg  = lmt_pkg::WIDTH_RESET;
    height_reg = lmt_pkg::HEIGHT_RESET;
    restart_frame();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_output_backpressure();
    test_wide_lines();
    test_random_frames();
    settle();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // receiver: own stall pattern plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      pattern_step <= pattern_step + 1;
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ((pattern_step % 7) < 3);
      endcase
    end
  end

  always @(posedge clk) begin : check_marks
    mark_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (marks_due.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none, actual mark=%b frame_end=%b",
                 $time, mark, frame_end);
      end else begin
        want = marks_due.pop_front();
        if (mark !== want.mark) begin
          fail_count++;
          $display("%0t: mark mismatch, expected %b actual %b", $time, want.mark, mark);
        end
        if (frame_end !== want.frame_end) begin
          fail_count++;
          $display("%0t: frame_end mismatch, expected %b actual %b",
                   $time, want.frame_end, frame_end);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

>>> local_mean_threshold_3x3.f
rtl/core/lmt_pkg.sv
rtl/core/lmt_ctrl.sv
rtl/core/lmt_linebuf.sv
rtl/core/lmt_judge.sv
rtl/core/local_mean_threshold_3x3.sv
dv/local_mean_threshold_3x3_tb.sv
